/* hdl/sjsd_pkg.sv */
// ----------------------------------------------------------------------------
// sjsd_pkg
// Shared types, codes and helpers for the strict JSON string decoder.
// ----------------------------------------------------------------------------
package sjsd_pkg;

  // scan phase of the lexer
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_U0   = 3'd3,
    PH_U1   = 3'd4,
    PH_UH   = 3'd5,
    PH_UL   = 3'd6,
    PH_UTF  = 3'd7
  } phase_t;

  // allowed range of the next utf-8 continuation byte
  typedef enum logic [2:0] {
    RNG_80_BF = 3'd0,
    RNG_A0_BF = 3'd1,
    RNG_80_9F = 3'd2,
    RNG_90_BF = 3'd3,
    RNG_80_8F = 3'd4
  } cont_range_t;

  // error codes
  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_NO_QUOTE    = 4'd1,
    ERR_CONTROL     = 4'd2,
    ERR_BAD_UTF8    = 4'd3,
    ERR_OPEN_ESC    = 4'd4,
    ERR_NONCANON_U  = 4'd5,
    ERR_BAD_HEX     = 4'd6,
    ERR_U_NONCTRL   = 4'd7,
    ERR_BAD_ESC     = 4'd8,
    ERR_UNTERM      = 4'd9
  } err_t;

  localparam int unsigned ByteW = 8;
  localparam int unsigned OutDataW = 16;

  // lexer state carried from byte to byte
  typedef struct packed {
    phase_t      phase;
    logic [1:0]  cont_left;
    cont_range_t cont_range;
    logic [3:0]  hex_hi;
    logic        hex_bad;
  } state_t;

  localparam state_t StateReset = '{
    phase: PH_IDLE, cont_left: 2'd0, cont_range: RNG_80_BF,
    hex_hi: 4'd0, hex_bad: 1'b0};

  // one result beat
  typedef struct packed {
    err_t             err;
    logic             done;
    logic             valid;
    logic [ByteW-1:0] data;
  } result_t;

  // hex digit decode: bit 4 set when not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) v = {1'b0, b[3:0]};
    else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
      v = {1'b0, b[3:0] + 4'd9};
    return v;
  endfunction

  // continuation byte range check
  function automatic logic cont_ok(input logic [7:0] b, input cont_range_t r);
    logic ok;
    case (r)
      RNG_A0_BF: ok = (b >= 8'ha0 && b <= 8'hbf);
      RNG_80_9F: ok = (b >= 8'h80 && b <= 8'h9f);
      RNG_90_BF: ok = (b >= 8'h90 && b <= 8'hbf);
      RNG_80_8F: ok = (b >= 8'h80 && b <= 8'h8f);
      default:   ok = (b >= 8'h80 && b <= 8'hbf);
    endcase
    return ok;
  endfunction

endpackage

/* hdl/sjsd_step.sv */
// ----------------------------------------------------------------------------
// sjsd_step
// Per-byte decode: next lexer state and result beat from the current state.
// ----------------------------------------------------------------------------
module sjsd_step (
  input  sjsd_pkg::state_t  cur,
  input  logic [7:0]        in_byte,
  input  logic              eoi,
  output sjsd_pkg::state_t  nxt,
  output sjsd_pkg::result_t res
);

  logic [4:0] hv;
  logic [7:0] uval;
  logic [1:0] left_dec;

  assign hv       = sjsd_pkg::hex_value(in_byte);
  assign uval     = {cur.hex_hi, hv[3:0]};
  assign left_dec = cur.cont_left - 2'd1;

  // decode one byte
  always_comb begin
    nxt        = cur;
    res.data   = '0;
    res.valid  = 1'b0;
    res.done   = 1'b0;
    res.err    = sjsd_pkg::ERR_NONE;
    case (cur.phase)
      sjsd_pkg::PH_BODY: begin
        if (in_byte == 8'h22) begin
          res.done = 1'b1;
          nxt      = sjsd_pkg::StateReset;
        end else if (in_byte < 8'h20) begin
          res.err = sjsd_pkg::ERR_CONTROL;
        end else if (in_byte >= 8'h80) begin
          if (in_byte inside {[8'hc2:8'hdf], [8'he0:8'hef], [8'hf0:8'hf4]} && !eoi) begin
            res.data       = in_byte;
            res.valid      = 1'b1;
            nxt.phase      = sjsd_pkg::PH_UTF;
            nxt.cont_range = sjsd_pkg::RNG_80_BF;
            if (in_byte <= 8'hdf) nxt.cont_left = 2'd1;
            else if (in_byte <= 8'hef) nxt.cont_left = 2'd2;
            else nxt.cont_left = 2'd3;
            if (in_byte == 8'he0) nxt.cont_range = sjsd_pkg::RNG_A0_BF;
            else if (in_byte == 8'hed) nxt.cont_range = sjsd_pkg::RNG_80_9F;
            else if (in_byte == 8'hf0) nxt.cont_range = sjsd_pkg::RNG_90_BF;
            else if (in_byte == 8'hf4) nxt.cont_range = sjsd_pkg::RNG_80_8F;
          end else begin
            res.err = sjsd_pkg::ERR_BAD_UTF8;
          end
        end else if (in_byte == 8'h5c) begin
          if (eoi) res.err = sjsd_pkg::ERR_OPEN_ESC;
          else nxt.phase = sjsd_pkg::PH_ESC;
        end else begin
          if (eoi) res.err = sjsd_pkg::ERR_UNTERM;
          else begin
            res.data  = in_byte;
            res.valid = 1'b1;
          end
        end
      end
      sjsd_pkg::PH_ESC: begin
        if (in_byte == 8'h75) begin
          if (eoi) res.err = sjsd_pkg::ERR_NONCANON_U;
          else nxt.phase = sjsd_pkg::PH_U0;
        end else if (!(in_byte inside {8'h22, 8'h5c, 8'h2f, 8'h62, 8'h66, 8'h6e,
                                       8'h72, 8'h74})) begin
          res.err = sjsd_pkg::ERR_BAD_ESC;
        end else if (eoi) begin
          res.err = sjsd_pkg::ERR_UNTERM;
        end else begin
          res.valid = 1'b1;
          nxt.phase = sjsd_pkg::PH_BODY;
          case (in_byte)
            8'h62:   res.data = 8'h08;
            8'h66:   res.data = 8'h0c;
            8'h6e:   res.data = 8'h0a;
            8'h72:   res.data = 8'h0d;
            8'h74:   res.data = 8'h09;
            default: res.data = in_byte;
          endcase
        end
      end
      sjsd_pkg::PH_U0, sjsd_pkg::PH_U1: begin
        if (eoi || in_byte != 8'h30) res.err = sjsd_pkg::ERR_NONCANON_U;
        else if (cur.phase == sjsd_pkg::PH_U0) nxt.phase = sjsd_pkg::PH_U1;
        else nxt.phase = sjsd_pkg::PH_UH;
      end
      sjsd_pkg::PH_UH: begin
        if (eoi) res.err = sjsd_pkg::ERR_NONCANON_U;
        else begin
          nxt.hex_bad = hv[4];
          nxt.hex_hi  = hv[3:0];
          nxt.phase   = sjsd_pkg::PH_UL;
        end
      end
      sjsd_pkg::PH_UL: begin
        if (cur.hex_bad || hv[4]) res.err = sjsd_pkg::ERR_BAD_HEX;
        else if (uval >= 8'h20) res.err = sjsd_pkg::ERR_U_NONCTRL;
        else if (eoi) res.err = sjsd_pkg::ERR_UNTERM;
        else begin
          res.data    = uval;
          res.valid   = 1'b1;
          nxt.hex_hi  = 4'd0;
          nxt.hex_bad = 1'b0;
          nxt.phase   = sjsd_pkg::PH_BODY;
        end
      end
      sjsd_pkg::PH_UTF: begin
        if (!sjsd_pkg::cont_ok(in_byte, cur.cont_range) || cur.cont_left == 2'd0) begin
          res.err = sjsd_pkg::ERR_BAD_UTF8;
        end else begin
          nxt.cont_left  = left_dec;
          nxt.cont_range = sjsd_pkg::RNG_80_BF;
          if (left_dec != 2'd0) begin
            if (eoi) res.err = sjsd_pkg::ERR_BAD_UTF8;
            else begin
              res.data  = in_byte;
              res.valid = 1'b1;
            end
          end else if (eoi) begin
            res.err = sjsd_pkg::ERR_UNTERM;
          end else begin
            res.data  = in_byte;
            res.valid = 1'b1;
            nxt.phase = sjsd_pkg::PH_BODY;
          end
        end
      end
      default: begin
        if (in_byte == 8'h22) begin
          if (eoi) res.err = sjsd_pkg::ERR_UNTERM;
          else nxt.phase = sjsd_pkg::PH_BODY;
        end else if (in_byte inside {8'h20, 8'h0a, 8'h0d, 8'h09}) begin
          if (eoi) res.err = sjsd_pkg::ERR_NO_QUOTE;
          else nxt = sjsd_pkg::StateReset;
        end else begin
          res.err = sjsd_pkg::ERR_NO_QUOTE;
        end
      end
    endcase

    // any error drops the beat payload and clears the lexer
    if (res.err != sjsd_pkg::ERR_NONE) begin
      res.data  = '0;
      res.valid = 1'b0;
      res.done  = 1'b0;
      nxt       = sjsd_pkg::StateReset;
    end
  end

endmodule

/* hdl/sjsd_out_reg.sv */
// ----------------------------------------------------------------------------
// sjsd_out_reg
// Result register of the decoder with its stream handshake.
// ----------------------------------------------------------------------------
module sjsd_out_reg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  sjsd_pkg::result_t                   res,
  output logic                                can_load,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sjsd_pkg::OutDataW-1:0]       out_tdata
);

  logic              vld_r;
  sjsd_pkg::result_t res_r;

  assign can_load   = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign out_tdata  = {{(sjsd_pkg::OutDataW - $bits(sjsd_pkg::result_t)){1'b0}}, res_r};

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

/* hdl/strict_json_string_decoder.sv */
// ----------------------------------------------------------------------------
// strict_json_string_decoder
// Lexes one JSON string per run of bytes, with strict UTF-8 checking.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one raw JSON byte per beat in in_tdata, in_tlast marks the last
//           byte of the text.
//   out_* : exactly one result beat per input beat. out_tdata carries the
//           decoded byte, a byte-valid flag, a string-done flag and an
//           error code (0 when ok). On error the consumer drops the string.
// Output: the result of a byte appears in out_* in the cycle after the byte
//   is accepted.
// Throughput: one byte per cycle while not stalled; the lexer state update is
//   a single level of byte decode between the state and result registers.
// Reset: rst_n (synchronous, active low) puts the lexer back to idle,
//   waiting for an opening quote, and empties the result register.
// Stall: while out_tready is low the result beat holds, and a new byte is
//   taken only when the result register is empty or is being drained.
// ----------------------------------------------------------------------------
module strict_json_string_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] in_byte
  input  logic                          in_tlast,   // end_of_input
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] out_byte, [8] out_valid, [9] string_done, [13:10] error_code,
  // [15:14] zero
  output logic [sjsd_pkg::OutDataW-1:0] out_tdata
);

  sjsd_pkg::state_t  state_r;
  sjsd_pkg::state_t  state_nxt;
  sjsd_pkg::result_t res;
  logic              accept;

  assign accept = in_tvalid && in_tready;

  // byte decode
  sjsd_step u_step (
    .cur     (state_r),
    .in_byte (in_tdata),
    .eoi     (in_tlast),
    .nxt     (state_nxt),
    .res     (res)
  );

  // lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sjsd_pkg::StateReset;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // result register
  sjsd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .res        (res),
    .can_load   (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* hdl/sjsd_checker.sv */
// ----------------------------------------------------------------------------
// sjsd_checker
// Port-level checks on the result stream of the decoder.
// ----------------------------------------------------------------------------
module sjsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // an error beat carries no byte and no done flag
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[13:10] != 4'd0 |-> out_tdata[9:0] == 10'd0)
    else $error("error beat carries payload");

  // a done beat delivers no byte
  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |-> !out_tdata[8] && out_tdata[7:0] == 8'd0)
    else $error("done beat carries a byte");

  // error code stays in its range
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[13:10] <= 4'd9 && out_tdata[15:14] == 2'd0)
    else $error("bad error code");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // a byte accepted gives a result beat in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted byte gave no result");

endmodule

bind strict_json_string_decoder sjsd_checker u_sjsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* dv/lex_monitor.sv */
// ----------------------------------------------------------------------------
// lex_monitor
// Watches both streams of the JSON string decoder, predicts each result beat
// from the accepted input bytes and compares the result beats field by field.
// ----------------------------------------------------------------------------
module lex_monitor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [7:0]                    in_tdata,
  input  logic                          in_tlast,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [sjsd_pkg::OutDataW-1:0] out_tdata,
  output int                            mismatch_total,
  output int                            results_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import sjsd_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam int         PrintCap  = 40;

  // predicted lexer state
  phase_t      lx_phase;
  logic [1:0]  lx_cont_left;
  cont_range_t lx_range;
  logic [3:0]  lx_hex_hi;
  logic        lx_hex_bad;

  // result beats still owed by the block, oldest first
  result_t owed_beats[$];

  function automatic void clear_lexer();
    lx_phase     = PH_IDLE;
    lx_cont_left = 2'd0;
    lx_range     = RNG_80_BF;
    lx_hex_hi    = 4'd0;
    lx_hex_bad   = 1'b0;
  endfunction

  // add a predicted beat at the tail of the owed list
  function automatic void owe_beat(input result_t r);
    owed_beats = {owed_beats, r};
  endfunction

  // hex digit value, bit 4 set for anything else
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h37);
    if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h57);
    return 5'h10;
  endfunction

  // one raw byte in, the result beat it causes out; advances the state
  function automatic result_t lex_byte(input logic [7:0] b, input logic eoi);
    result_t     r;
    err_t        e;
    logic [1:0]  n_cont;
    cont_range_t rg;
    logic        in_rng;
    logic        esc_ok;
    logic [7:0]  esc_val;
    logic [4:0]  lo_dig;
    logic [4:0]  hi_dig;
    logic [7:0]  val;
    r       = '0;
    e       = ERR_NONE;
    esc_ok  = 1'b1;
    esc_val = 8'h00;
    case (lx_phase)
      PH_BODY: begin
        if (b == CH_QUOTE) begin
          r.done = 1'b1;
        end else if (b < 8'h20) begin
          e = ERR_CONTROL;
        end else if (b >= 8'h80) begin
          // classify the utf-8 lead byte
          n_cont = 2'd0;
          rg     = RNG_80_BF;
          if (b >= 8'hc2 && b <= 8'hdf) n_cont = 2'd1;
          else if (b == 8'he0) begin
            n_cont = 2'd2;
            rg     = RNG_A0_BF;
          end else if (b == 8'hed) begin
            n_cont = 2'd2;
            rg     = RNG_80_9F;
          end else if (b >= 8'he1 && b <= 8'hef) n_cont = 2'd2;
          else if (b == 8'hf0) begin
            n_cont = 2'd3;
            rg     = RNG_90_BF;
          end else if (b == 8'hf4) begin
            n_cont = 2'd3;
            rg     = RNG_80_8F;
          end else if (b >= 8'hf1 && b <= 8'hf3) n_cont = 2'd3;
          if (n_cont == 2'd0 || eoi) begin
            e = ERR_BAD_UTF8;
          end else begin
            r.data       = b;
            r.valid      = 1'b1;
            lx_cont_left = n_cont;
            lx_range     = rg;
            lx_phase     = PH_UTF;
          end
        end else if (b == CH_BSLASH) begin
          if (eoi) e = ERR_OPEN_ESC;
          else lx_phase = PH_ESC;
        end else if (eoi) begin
          e = ERR_UNTERM;
        end else begin
          r.data  = b;
          r.valid = 1'b1;
        end
      end
      PH_ESC: begin
        case (b)
          CH_QUOTE, CH_BSLASH, CH_SLASH: esc_val = b;
          8'h62:   esc_val = 8'h08;  // b
          8'h66:   esc_val = 8'h0c;  // f
          8'h6e:   esc_val = 8'h0a;  // n
          8'h72:   esc_val = 8'h0d;  // r
          8'h74:   esc_val = 8'h09;  // t
          default: esc_ok = 1'b0;
        endcase
        if (b == CH_U) begin
          if (eoi) e = ERR_NONCANON_U;
          else lx_phase = PH_U0;
        end else if (!esc_ok) begin
          e = ERR_BAD_ESC;
        end else if (eoi) begin
          e = ERR_UNTERM;
        end else begin
          r.data   = esc_val;
          r.valid  = 1'b1;
          lx_phase = PH_BODY;
        end
      end
      PH_U0, PH_U1: begin
        if (eoi || b != CH_ZERO) e = ERR_NONCANON_U;
        else lx_phase = (lx_phase == PH_U0) ? PH_U1 : PH_UH;
      end
      PH_UH: begin
        // a bad high digit is only reported on the low digit
        hi_dig = hex_of(b);
        if (eoi) begin
          e = ERR_NONCANON_U;
        end else begin
          lx_hex_bad = hi_dig[4];
          lx_hex_hi  = hi_dig[3:0];
          lx_phase   = PH_UL;
        end
      end
      PH_UL: begin
        lo_dig = hex_of(b);
        val    = {lx_hex_hi, lo_dig[3:0]};
        if (lx_hex_bad || lo_dig[4]) e = ERR_BAD_HEX;
        else if (val >= 8'h20) e = ERR_U_NONCTRL;
        else if (eoi) e = ERR_UNTERM;
        else begin
          r.data     = val;
          r.valid    = 1'b1;
          lx_hex_hi  = 4'd0;
          lx_hex_bad = 1'b0;
          lx_phase   = PH_BODY;
        end
      end
      PH_UTF: begin
        case (lx_range)
          RNG_A0_BF: in_rng = (b >= 8'ha0 && b <= 8'hbf);
          RNG_80_9F: in_rng = (b >= 8'h80 && b <= 8'h9f);
          RNG_90_BF: in_rng = (b >= 8'h90 && b <= 8'hbf);
          RNG_80_8F: in_rng = (b >= 8'h80 && b <= 8'h8f);
          default:   in_rng = (b >= 8'h80 && b <= 8'hbf);
        endcase
        if (!in_rng || lx_cont_left == 2'd0) begin
          e = ERR_BAD_UTF8;
        end else begin
          lx_cont_left = lx_cont_left - 2'd1;
          lx_range     = RNG_80_BF;
          if (lx_cont_left != 2'd0) begin
            // sequence still incomplete
            if (eoi) e = ERR_BAD_UTF8;
            else begin
              r.data  = b;
              r.valid = 1'b1;
            end
          end else if (eoi) begin
            e = ERR_UNTERM;
          end else begin
            r.data   = b;
            r.valid  = 1'b1;
            lx_phase = PH_BODY;
          end
        end
      end
      default: begin
        // idle: skip whitespace, wait for the opening quote
        if (b == CH_QUOTE) begin
          if (eoi) e = ERR_UNTERM;
          else lx_phase = PH_BODY;
        end else if (b == 8'h20 || b == 8'h0a || b == 8'h0d || b == 8'h09) begin
          if (eoi) e = ERR_NO_QUOTE;
        end else begin
          e = ERR_NO_QUOTE;
        end
      end
    endcase
    if (e != ERR_NONE) r = '0;
    r.err = e;
    if (e != ERR_NONE || r.done) clear_lexer();
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatch_total++;
    if (mismatch_total <= PrintCap)
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // predict on each input beat, check each result beat
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      clear_lexer();
      owed_beats.delete();
    end else begin
      if (in_tvalid && in_tready) owe_beat(lex_byte(in_tdata, in_tlast));
      if (out_tvalid && out_tready) begin
        if (owed_beats.size() == 0) begin
          report_mismatch("unexpected result beat", out_tdata, 16'h0);
        end else begin
          want = owed_beats.pop_front();
          got  = out_tdata[13:0];
          if (got.data !== want.data)
            report_mismatch("out_byte", 16'(got.data), 16'(want.data));
          if (got.valid !== want.valid)
            report_mismatch("out_valid", 16'(got.valid), 16'(want.valid));
          if (got.done !== want.done)
            report_mismatch("string_done", 16'(got.done), 16'(want.done));
          if (got.err !== want.err)
            report_mismatch("error_code", 16'(got.err), 16'(want.err));
          if (out_tdata[15:14] !== 2'b00)
            report_mismatch("pad bits", 16'(out_tdata[15:14]), 16'h0);
        end
      end
    end
    results_owed <= owed_beats.size();
  end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Byte-stream test of the strict JSON string decoder: a short directed run,
// then random JSON texts (mostly well-formed strings with escapes, \u00XY and
// UTF-8, some corrupted or cut short) with random idling on both streams.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sjsd_pkg::*;

  typedef logic [7:0] text_t[$];

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata   = 8'h00;
  logic                in_tlast   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;

  int mismatch_total;
  int results_owed;
  bit stalls_on = 1'b0;
  int stall_left;
  int sent_bytes;

  always #5 clk = ~clk;

  strict_json_string_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  lex_monitor u_mon (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_total (mismatch_total),
    .results_owed   (results_owed)
  );

  // result side backpressure in random bursts
  always @(negedge clk) begin
    if (!stalls_on) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // add one byte at the end of a text
  function automatic void append_byte(ref text_t q, input logic [7:0] b);
    q = {q, b};
  endfunction

  // one input beat; called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (stalls_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_bytes(input text_t txt, input bit mark_last);
    foreach (txt[i]) send_byte(txt[i], mark_last && (i == txt.size() - 1));
    sent_bytes += txt.size();
  endtask

  // one random text: whitespace, a string of random tokens, then maybe
  // corrupted, cut short or left open
  task automatic send_random_text();
    text_t      t;
    string      hexd  = "0123456789abcdefABCDEF";
    string      escs  = "\"\\/bfnrt";
    string      blank = " \n\r\t";
    int         n_ws;
    int         cut;
    bit         mark_last;
    logic [7:0] lead;
    n_ws = $urandom_range(0, 2);
    repeat (n_ws) append_byte(t, blank[$urandom_range(0, 3)]);
    append_byte(t, 8'h22);
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 9))
        4: begin
          append_byte(t, 8'h5c);
          append_byte(t, escs[$urandom_range(0, 7)]);
        end
        5: begin
          // \u00XY, mostly a control value
          append_byte(t, 8'h5c);
          append_byte(t, 8'h75);
          append_byte(t, 8'h30);
          append_byte(t, 8'h30);
          append_byte(t, ($urandom_range(0, 4) != 0) ? hexd[$urandom_range(0, 1)]
                                                     : hexd[$urandom_range(0, 21)]);
          append_byte(t, hexd[$urandom_range(0, 21)]);
        end
        6: begin
          append_byte(t, 8'($urandom_range(8'hc2, 8'hdf)));
          append_byte(t, 8'($urandom_range(8'h80, 8'hbf)));
        end
        7: begin
          lead = ($urandom_range(0, 2) == 0) ? ($urandom_range(0, 1) ? 8'he0 : 8'hed)
                                             : 8'($urandom_range(8'he0, 8'hef));
          append_byte(t, lead);
          if (lead == 8'he0) append_byte(t, 8'($urandom_range(8'ha0, 8'hbf)));
          else if (lead == 8'hed) append_byte(t, 8'($urandom_range(8'h80, 8'h9f)));
          else append_byte(t, 8'($urandom_range(8'h80, 8'hbf)));
          append_byte(t, 8'($urandom_range(8'h80, 8'hbf)));
        end
        8: begin
          lead = ($urandom_range(0, 2) == 0) ? ($urandom_range(0, 1) ? 8'hf0 : 8'hf4)
                                             : 8'($urandom_range(8'hf0, 8'hf4));
          append_byte(t, lead);
          if (lead == 8'hf0) append_byte(t, 8'($urandom_range(8'h90, 8'hbf)));
          else if (lead == 8'hf4) append_byte(t, 8'($urandom_range(8'h80, 8'h8f)));
          else append_byte(t, 8'($urandom_range(8'h80, 8'hbf)));
          append_byte(t, 8'($urandom_range(8'h80, 8'hbf)));
          append_byte(t, 8'($urandom_range(8'h80, 8'hbf)));
        end
        9: append_byte(t, 8'($urandom_range(0, 255)));
        default: begin
          // plain byte, now and then a control byte
          if ($urandom_range(0, 15) == 0) append_byte(t, 8'($urandom_range(8'h00, 8'h1f)));
          else append_byte(t, 8'($urandom_range(8'h20, 8'h7f)));
        end
      endcase
      // break a utf-8 continuation with a quote, a backslash or noise
      if (t[$] >= 8'h80 && $urandom_range(0, 11) == 0)
        t[$] = ($urandom_range(0, 2) == 0) ? 8'h22
             : ($urandom_range(0, 1) ? 8'h5c : 8'($urandom_range(0, 255)));
    end
    append_byte(t, 8'h22);
    if ($urandom_range(0, 5) == 0)
      t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      cut       = $urandom_range(0, t.size() - 1);
      t         = t[0:cut];
      mark_last = 1'b1;
    end else begin
      mark_last = 1'($urandom_range(0, 1));
    end
    send_bytes(t, mark_last);
  endtask

  // stimulus and verdict
  initial begin
    repeat (8) @(negedge clk);
    rst_n     <= 1'b1;
    stalls_on = 1'b1;

    // whitespace, \u001F, \/, \b, U+10FFFF, closing quote at end of input
    send_bytes({8'h09, 8'h20, 8'h22, 8'h5c, 8'h75, 8'h30, 8'h30, 8'h31, 8'h46,
                8'h5c, 8'h2f, 8'h5c, 8'h62, 8'hf4, 8'h8f, 8'hbf, 8'hbf, 8'h22}, 1'b1);
    // bad escape letter
    send_bytes({8'h22, 8'h5c, 8'h78}, 1'b0);
    // no opening quote
    send_bytes({8'hff}, 1'b0);
    // input ends inside the body
    send_bytes({8'h22, 8'h61}, 1'b1);
    // input ends right after \u
    send_bytes({8'h22, 8'h5c, 8'h75}, 1'b1);

    while (sent_bytes < 130) send_random_text();

    // hold the sender until every owed result has come back
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);

    stalls_on = 1'b0;
    while (sent_bytes < 200) send_random_text();
    stalls_on = 1'b1;
    while (sent_bytes < 330) send_random_text();
    stalls_on = 1'b0;
    while (sent_bytes < 395) send_random_text();

    // drain
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatch_total == 0 && results_owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* sim.f */
hdl/sjsd_pkg.sv
hdl/sjsd_step.sv
hdl/sjsd_out_reg.sv
hdl/strict_json_string_decoder.sv
hdl/sjsd_checker.sv
dv/lex_monitor.sv
dv/tb.sv
